FILE: rtl/rtd_trimmed_mean_to_celsius_core_defines.svh
// Assertion macros for the RTD trimmed-mean core.
// Included by the top level; no other dependencies.
`ifndef RTD_TRIMMED_MEAN_TO_CELSIUS_CORE_DEFINES_SVH
`define RTD_TRIMMED_MEAN_TO_CELSIUS_CORE_DEFINES_SVH

// Same-cycle implication check on the rising clock edge.
`define RTD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication check on the rising clock edge.
`define RTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/rtdtm_pkg.sv
// Shared constants, types and state codes for the RTD trimmed-mean core.
// No dependencies.
`default_nettype none
package rtdtm_pkg;
   localparam int AvgShift = 4;
   localparam int IterMax  = 16;
   localparam int BlockLen = (1 << AvgShift) + 2;
   localparam int IterW    = $clog2(IterMax + 1);

   localparam logic [32:0] KDen   = 33'd7116787724;
   localparam logic [30:0] CoefA  = 31'd1678481809;
   localparam logic [17:0] CoefB  = 18'd249192;
   localparam logic [22:0] R0Q16  = 23'd6553600;
   localparam logic [8:0]  TolQ16 = 9'd328;
   localparam logic [31:0] Recip9 = 32'd477218588;
   localparam logic [12:0] Recip10 = 13'd6554;

   localparam int NumW  = 57;
   localparam int DenW  = 33;
   localparam int QuotW = 25;

   typedef struct packed {
      logic              start;
      logic [NumW-1:0]   num;
      logic [DenW-1:0]   den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QuotW-1:0]  quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIVIDE, ST_DIV9_MUL, ST_DIV9_FIX, ST_UPDATE, ST_MUL_B,
      ST_POLY, ST_MUL_T, ST_RESID, ST_CENTI, ST_CLAMP, ST_DIGIT, ST_EMIT
   } back_state_type;
endpackage
`default_nettype wire

FILE: rtl/rtdtm_front.sv
// Front end: accumulates sample blocks and produces the trimmed mean.
// Depends on rtdtm_pkg.
`default_nettype none
module rtdtm_front import rtdtm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [9:0] sample,
   output logic            push,
   output logic [9:0]      avg
);
   logic [6:0]  count_ff, count_in;
   logic [16:0] sum_ff, sum_in;
   logic [9:0]  max_ff, max_in, min_ff, min_in;
   logic [16:0] t1, t2;
   logic        last;

   // Fold the new sample into the running block
   always_comb begin
      sum_in = sum_ff + {7'd0, sample};
      max_in = (sample > max_ff) ? sample : max_ff;
      min_in = (sample < min_ff) ? sample : min_ff;
      count_in = count_ff + 7'd1;
      last = (count_in == 7'(BlockLen));
      t1 = (sum_in >= {7'd0, max_in}) ? sum_in - {7'd0, max_in} : 17'd0;
      t2 = (t1 >= {7'd0, min_in}) ? t1 - {7'd0, min_in} : 17'd0;
      avg = 10'(t2 >> AvgShift);
      push = accept && last;
   end

   // Advance block state; restart on the last sample
   always_ff @(posedge clock) begin
      if (reset || push) begin
         count_ff <= '0;
         sum_ff   <= '0;
         max_ff   <= '0;
         min_ff   <= 10'd1023;
      end else if (accept) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/rtdtm_fifo.sv
// Two-entry queue of block averages between front and back ends.
// Depends on rtdtm_pkg.
`default_nettype none
module rtdtm_fifo import rtdtm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [9:0] wdata,
   input  wire logic       pop,
   output logic [9:0]      rdata,
   output logic            empty,
   output logic            full
);
   logic [9:0] mem [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign rdata = mem[rp_ff];

   // Write the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wp_ff] <= wdata;
      end
   end

   // Move pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

FILE: rtl/rtdtm_div.sv
// Restoring divider, one quotient bit per cycle, for the resistance.
// Depends on rtdtm_pkg.
`default_nettype none
module rtdtm_div import rtdtm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [NumW-1:0]  num_ff;
   logic [DenW-1:0]  den_ff;
   logic [DenW-1:0]  rem_ff;
   logic [DenW:0]    rem2;
   logic [QuotW-1:0] q_ff;
   logic [5:0]       cnt_ff;
   logic             busy_ff, done_ff;
   logic             ge;

   always_comb begin
      rem2 = {rem_ff, num_ff[NumW-1]};
      ge   = (rem2 >= {1'b0, den_ff});
   end

   // Shift in one dividend bit and subtract when it fits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(NumW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff <= req.num;
         den_ff <= req.den;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NumW-2:0], 1'b0};
         rem_ff <= ge ? DenW'(rem2 - {1'b0, den_ff}) : rem2[DenW-1:0];
         q_ff   <= {q_ff[QuotW-2:0], ge};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;
endmodule
`default_nettype wire

FILE: rtl/rtdtm_back.sv
// Back end: resistance, Newton iteration, hundredths and display digits.
// Depends on rtdtm_pkg and rtdtm_div.
`default_nettype none
module rtdtm_back import rtdtm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  wire logic [9:0]  q_data,
   output logic             q_pop,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [43:0]      out_data
);
   back_state_type state_ff, state_in;
   div_req_type    dreq;
   div_rsp_type    drsp;

   logic [9:0]         avg_ff;
   logic [24:0]        r_ff;
   logic signed [25:0] t_ff;
   logic signed [28:0] res_ff;
   logic [32:0]        mag_ff;
   logic               neg_ff, init_ff, lim_ff, clamp_ff;
   logic [29:0]        q9_ff;
   logic signed [44:0] pb_ff;
   logic signed [32:0] poly_ff;
   logic signed [58:0] pt_ff;
   logic [IterW-1:0]   it_ff;
   logic signed [15:0] centi_ff;
   logic [13:0]        disp_ff;
   logic [15:0]        dig_ff;
   logic [1:0]         dcnt_ff;
   logic               ovalid_ff;
   logic [43:0]        odata_ff;

   // Datapath helper values
   logic signed [28:0] res_new, res_init;
   logic [64:0]        p9;
   logic [33:0]        q9x9;
   logic signed [30:0] tsum, step;
   logic signed [32:0] x100;
   logic signed [16:0] c17;
   logic [26:0]        pd;
   logic [13:0]        dq;
   logic [3:0]         dr;
   logic               conv, out_free;

   rtdtm_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      res_init = $signed({4'd0, drsp.quot}) - $signed({6'd0, R0Q16});
      res_new  = $signed({4'd0, r_ff})
                 - ($signed({6'd0, R0Q16}) + 29'(pt_ff >>> 32));
      p9       = {32'd0, mag_ff} * {33'd0, Recip9};
      q9x9     = {4'd0, q9_ff} * 34'd9;
      step     = neg_ff ? -$signed({1'b0, q9_ff}) : $signed({1'b0, q9_ff});
      tsum     = (init_ff ? 31'sd0 : 31'(t_ff)) + step;
      conv     = (res_ff <= $signed({20'd0, TolQ16}))
                 && (res_ff >= -$signed({20'd0, TolQ16}));
      x100     = 33'(t_ff) * 33'sd100;
      c17      = (x100 < 0) ? -$signed(17'((-x100) >>> 16)) : 17'(x100 >>> 16);
      pd       = {13'd0, disp_ff} * {14'd0, Recip10};
      dq       = 14'(pd >> 16);
      dr       = 4'(disp_ff - 14'(dq * 14'd10));
      out_free = !ovalid_ff || out_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (!q_empty) state_in = ST_DIVIDE;
         ST_DIVIDE:   if (drsp.done) state_in = ST_DIV9_MUL;
         ST_DIV9_MUL: state_in = ST_DIV9_FIX;
         ST_DIV9_FIX: if (q9x9 + 34'd9 > {1'b0, mag_ff}) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (init_ff) state_in = ST_MUL_B;
            else if (conv || (it_ff == IterW'(IterMax - 1))) state_in = ST_CENTI;
            else state_in = ST_MUL_B;
         end
         ST_MUL_B:    state_in = ST_POLY;
         ST_POLY:     state_in = ST_MUL_T;
         ST_MUL_T:    state_in = ST_RESID;
         ST_RESID:    state_in = ST_DIV9_MUL;
         ST_CENTI:    state_in = ST_CLAMP;
         ST_CLAMP:    state_in = ST_DIGIT;
         ST_DIGIT:    if (dcnt_ff == 2'd2) state_in = ST_EMIT;
         ST_EMIT:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      q_pop      = 1'b0;
      dreq.start = 1'b0;
      dreq.num   = {25'd19350 * {15'd0, q_data}, 32'd0};
      dreq.den   = KDen - {4'd0, {3'd0, q_data} * 13'd5, 16'd0};
      unique case (state_ff)
         ST_IDLE: begin
            q_pop      = !q_empty;
            dreq.start = !q_empty;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: avg_ff <= q_data;
         ST_DIVIDE: begin
            r_ff    <= drsp.quot;
            res_ff  <= res_init;
            init_ff <= 1'b1;
            neg_ff  <= res_init < 0;
            mag_ff  <= 33'((res_init < 0) ? -(34'(res_init) * 34'sd25)
                                           : 34'(res_init) * 34'sd25);
         end
         ST_DIV9_MUL: q9_ff <= 30'(p9 >> 32);
         ST_DIV9_FIX: if (q9x9 + 34'd9 <= {1'b0, mag_ff}) q9_ff <= q9_ff + 30'd1;
         ST_UPDATE: begin
            if (tsum > 31'sd33554431)       t_ff <= 26'sd33554431;
            else if (tsum < -31'sd33554432) t_ff <= -26'sd33554432;
            else                            t_ff <= 26'(tsum);
            if (init_ff) begin
               init_ff <= 1'b0;
               it_ff   <= '0;
            end else begin
               it_ff  <= it_ff + IterW'(1);
               lim_ff <= !conv;
            end
         end
         ST_MUL_B: pb_ff   <= $signed({1'b0, CoefB}) * t_ff;
         ST_POLY:  poly_ff <= $signed({2'd0, CoefA}) - 33'(pb_ff >>> 16);
         ST_MUL_T: pt_ff   <= 59'(t_ff) * 59'(poly_ff);
         ST_RESID: begin
            res_ff <= res_new;
            neg_ff <= res_new < 0;
            mag_ff <= 33'((res_new < 0) ? -(34'(res_new) * 34'sd25)
                                        : 34'(res_new) * 34'sd25);
         end
         ST_CENTI: begin
            if (c17 > 17'sd25000)       centi_ff <= 16'sd25000;
            else if (c17 < -17'sd25000) centi_ff <= -16'sd25000;
            else                        centi_ff <= 16'(c17);
         end
         ST_CLAMP: begin
            clamp_ff <= (centi_ff < 0) || (centi_ff > 16'sd9999);
            disp_ff  <= (centi_ff < 0) ? 14'd0
                        : (centi_ff > 16'sd9999) ? 14'd9999 : 14'(centi_ff);
            dcnt_ff  <= 2'd0;
         end
         ST_DIGIT: begin
            // Peel one digit per cycle, hundredths first; the last pass keeps the tens too
            if (dcnt_ff == 2'd2) dig_ff[15:8] <= {dq[3:0], dr};
            else                 dig_ff[dcnt_ff*4 +: 4] <= dr;
            disp_ff <= dq;
            dcnt_ff <= dcnt_ff + 2'd1;
         end
         default: ;
      endcase
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && out_free) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   // Pack tens digit lowest, hundredths highest
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         odata_ff <= {lim_ff, clamp_ff, dig_ff[3:0], dig_ff[7:4],
                      dig_ff[11:8], dig_ff[15:12], centi_ff, avg_ff};
      end
   end

   assign out_valid = ovalid_ff;
   assign out_data  = odata_ff;
endmodule
`default_nettype wire

FILE: rtl/rtd_trimmed_mean_to_celsius_core.sv
// RTD core: one sample per cycle at the input while the queue is not full, one
// result per block of 18. Each block's conversion runs the bit-serial
// resistance divider and then up to 16 Newton steps of the multiplier sequence.
// A two-entry queue lets sampling continue meanwhile.
// Synchronous active-high reset clears block counters, queue and sequencer.
`default_nettype none
`include "rtd_trimmed_mean_to_celsius_core_defines.svh"
module rtd_trimmed_mean_to_celsius_core import rtdtm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [9:0] adc_sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [9:0] sample_average, [25:10] temp_centi, [29:26] digit_tens,
   // [33:30] digit_units, [37:34] digit_tenths, [41:38] digit_hundredths,
   // [42] display_clamped, [43] iteration_limited
   output logic [47:0]      rsp_tdata
);
   logic       accept, push, pop, empty, full;
   logic [9:0] avg, qdata;
   logic [43:0] odata;
   logic       digits_ok, centi_ok, disp_ok;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   rtdtm_front u_front (.clock(clock), .reset(reset), .accept(accept),
                        .sample(req_tdata[9:0]), .push(push), .avg(avg));

   rtdtm_fifo u_fifo (.clock(clock), .reset(reset), .push(push), .wdata(avg),
                      .pop(pop), .rdata(qdata), .empty(empty), .full(full));

   rtdtm_back u_back (.clock(clock), .reset(reset), .q_empty(empty),
                      .q_data(qdata), .q_pop(pop), .out_valid(rsp_tvalid),
                      .out_ready(rsp_tready), .out_data(odata));

   assign rsp_tdata = {4'd0, odata};

   assign digits_ok = (rsp_tdata[29:26] <= 4'd9) && (rsp_tdata[33:30] <= 4'd9)
                      && (rsp_tdata[37:34] <= 4'd9) && (rsp_tdata[41:38] <= 4'd9);
   assign centi_ok  = ($signed(rsp_tdata[25:10]) <= 16'sd25000)
                      && ($signed(rsp_tdata[25:10]) >= -16'sd25000);
   assign disp_ok   = ($signed(rsp_tdata[25:10]) >= 16'sd0)
                      && ($signed(rsp_tdata[25:10]) <= 16'sd9999);

   // Digits stay decimal
   `RTD_ASSERT_NOW(a_digits, clock, reset, rsp_tvalid, digits_ok)
   // Temperature stays inside its saturation range
   `RTD_ASSERT_NOW(a_range, clock, reset, rsp_tvalid, centi_ok)
   // Unclamped display implies an in-range temperature
   `RTD_ASSERT_NOW(a_clamp, clock, reset, rsp_tvalid && !rsp_tdata[42], disp_ok)
endmodule
`default_nettype wire
